/* rtl/rlcr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rlcr_pkg;

  localparam int RLCR_WINDOW_DEPTH = 16;
  localparam int RLCR_MAX_CHUNKS   = 4;
  localparam int SN_W              = 32;
  localparam int LEN_W             = 16;
  localparam int MAX_RESULTS       = 64;
  localparam int RES_CNT_W         = 7;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 16;
  localparam int WSIZE_W           = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE     = 2'd0,
    CFG_REORDER_TIMEOUT = 2'd1,
    CFG_FIRST_PDU_START = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EV_DELIVER   = 2'd0,
    EV_DISCARD   = 2'd1,
    EV_FRAG_DROP = 2'd2,
    EV_LEN_ERR   = 2'd3
  } ev_t;

  typedef enum logic [1:0] {
    ACT_WHOLE = 2'd0,
    ACT_FIRST = 2'd1,
    ACT_LAST  = 2'd2,
    ACT_MID   = 2'd3
  } act_t;

  typedef struct packed {
    logic [SN_W-1:0]  sdu_sn;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] sdu_len;
  } chunk_t;

  typedef struct packed {
    ev_t              kind;
    logic [SN_W-1:0]  sn;
    logic [LEN_W-1:0] len;
  } res_t;

endpackage
`default_nettype wire

/* rtl/rlcr_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface rlcr_item_if import rlcr_pkg::*;;
  logic             valid;
  logic             ready;
  logic             func;
  logic [SN_W-1:0]  pdu_sn;
  logic [1:0]       framing_info;
  logic             chunk_last;
  logic [LEN_W-1:0] chunk_len;
  logic [SN_W-1:0]  sdu_sn;
  logic [LEN_W-1:0] sdu_len;
  modport source (output valid, func, pdu_sn, framing_info, chunk_last, chunk_len, sdu_sn,
                  sdu_len, input ready);
  modport sink (input valid, func, pdu_sn, framing_info, chunk_last, chunk_len, sdu_sn,
                sdu_len, output ready);
endinterface

interface rlcr_result_if import rlcr_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       event_kind;
  logic [SN_W-1:0]  out_sdu_sn;
  logic [LEN_W-1:0] out_sdu_len;
  logic             last;
  modport source (output valid, event_kind, out_sdu_sn, out_sdu_len, last, input ready);
  modport sink (input valid, event_kind, out_sdu_sn, out_sdu_len, last, output ready);
endinterface

interface rlcr_cfg_if import rlcr_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/rlcr_store.sv */
`timescale 1ns / 1ps
`default_nettype none
module rlcr_store import rlcr_pkg::*; #(
  parameter int WINDOW_DEPTH = RLCR_WINDOW_DEPTH,
  parameter int MAX_CHUNKS   = RLCR_MAX_CHUNKS,
  localparam int SW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
  localparam int CW = $clog2(MAX_CHUNKS + 1),
  localparam int AW = (WINDOW_DEPTH * MAX_CHUNKS > 1) ? $clog2(WINDOW_DEPTH * MAX_CHUNKS) : 1
) (
  input  wire logic          clk,
  input  wire logic          c_we,
  input  wire logic [AW-1:0] c_waddr,
  input  wire chunk_t        c_wdata,
  input  wire logic [AW-1:0] c_raddr,
  output chunk_t             c_rdata,
  input  wire logic          i_we,
  input  wire logic [SW-1:0] i_waddr,
  input  wire logic [1:0]    i_wfi,
  input  wire logic [CW-1:0] i_wcnt,
  input  wire logic [SW-1:0] i_raddr,
  output logic [1:0]         i_rfi,
  output logic [CW-1:0]      i_rcnt
);

  chunk_t               cmem [WINDOW_DEPTH*MAX_CHUNKS];
  logic   [CW+1:0]      imem [WINDOW_DEPTH];

  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[c_waddr] <= c_wdata;
    end
    c_rdata <= cmem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (i_we) begin
      imem[i_waddr] <= {i_wfi, i_wcnt};
    end
    {i_rfi, i_rcnt} <= imem[i_raddr];
  end

endmodule
`default_nettype wire

/* rtl/rlcr_outq.sv */
`timescale 1ns / 1ps
`default_nettype none
module rlcr_outq import rlcr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire res_t      push_data,
  input  wire logic      flush,
  output logic           rdy,
  rlcr_result_if.source  result
);

  res_t                 pend;
  logic                 pend_v;
  res_t                 outr;
  logic                 out_last;
  logic                 out_v;
  logic [RES_CNT_W-1:0] cnt;
  logic                 free;
  logic                 cap;

  assign free = !out_v || result.ready;
  assign cap  = (cnt == RES_CNT_W'(MAX_RESULTS));
  assign rdy  = !pend_v || free;

  assign result.valid       = out_v;
  assign result.event_kind  = outr.kind;
  assign result.out_sdu_sn  = outr.sn;
  assign result.out_sdu_len = outr.len;
  assign result.last        = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      out_v  <= 1'b0;
      cnt    <= '0;
    end else begin
      if (out_v && result.ready) begin
        out_v <= 1'b0;
      end
      if (push && rdy && !cap) begin
        if (pend_v) begin
          outr     <= pend;
          out_last <= 1'b0;
          out_v    <= 1'b1;
        end
        pend   <= push_data;
        pend_v <= 1'b1;
        cnt    <= cnt + 1'b1;
      end
      if (flush && rdy) begin
        if (pend_v) begin
          outr     <= pend;
          out_last <= 1'b1;
          out_v    <= 1'b1;
        end
        pend_v <= 1'b0;
        cnt    <= '0;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/rlc_um_reorder_reassemble.sv */
`timescale 1ns / 1ps
`default_nettype none
// receive side of an unacknowledged-mode link: pdu reordering and sdu reassembly
// item channel: one beat is either an sdu chunk descriptor (func 0) or a timer tick (func 1);
//   the chunk with chunk_last set closes its pdu and triggers window handling
// result channel: zero to 64 beats per item, last marks the final beat of that item
// cfg channel: register writes, always ready; user writes only while the block is idle
// throughput: one item at a time, ready high only when idle; cfg writes are not gated
// sequence: a chunk that does not close a pdu and a plain tick go straight to done;
//   a closing chunk is checked, slides the window if needed, reassembling the slots
//   that leave it, is copied into the store, advances the reordering point, reassembles
//   every slot that it passes and updates the timer; an expiring tick moves the point
//   to the trigger, reassembles likewise and may rearm the timer
// the chunk store and the pdu info table have a write and a read port and registered
//   reads, walked by one sequencer; the window is a circular buffer with a base slot
// reset clears the window, the timer, the held sdu and the staged chunks; no sweep
// a stalled result receiver holds one beat in the output register and one pending,
//   after which the sequencer waits
module rlc_um_reorder_reassemble import rlcr_pkg::*; #(
  parameter int WINDOW_DEPTH = RLCR_WINDOW_DEPTH,
  parameter int MAX_CHUNKS   = RLCR_MAX_CHUNKS
) (
  input  wire logic     clk,
  input  wire logic     rst,
  rlcr_item_if.sink     item,
  rlcr_result_if.source result,
  rlcr_cfg_if.sink      cfg
);

  localparam int SW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW  = $clog2(MAX_CHUNKS + 1);
  localparam int CIW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int AW  = (WINDOW_DEPTH * MAX_CHUNKS > 1) ? $clog2(WINDOW_DEPTH * MAX_CHUNKS) : 1;
  localparam int KW  = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [18:0] {
    S_IDLE      = 19'h00001,
    S_P_CHECK   = 19'h00002,
    S_P_DISC    = 19'h00004,
    S_SH_LOOP   = 19'h00008,
    S_SH_FIX    = 19'h00010,
    S_P_STORE   = 19'h00020,
    S_P_COPY    = 19'h00040,
    S_W_STEP    = 19'h00080,
    S_W_RA_INIT = 19'h00100,
    S_W_RA_LOOP = 19'h00200,
    S_RA_START  = 19'h00400,
    S_RA_READ   = 19'h00800,
    S_RA_INFO   = 19'h01000,
    S_RA_CHK    = 19'h02000,
    S_RA_ACT    = 19'h04000,
    S_P_TIMER   = 19'h08000,
    S_T_END     = 19'h10000,
    S_EMIT      = 19'h20000,
    S_DONE      = 19'h40000
  } state_t;

  function automatic logic [SW-1:0] phys_fn(logic [SW-1:0] off, logic [SW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, b} + {1'b0, off};
    if (s >= (SW+1)'(WINDOW_DEPTH)) s = s - (SW+1)'(WINDOW_DEPTH);
    return s[SW-1:0];
  endfunction

  function automatic logic rx_fn(logic [SN_W-1:0] v, logic [SN_W-1:0] w, logic [SW-1:0] b,
                                 logic [WINDOW_DEPTH-1:0] m);
    logic [SN_W:0] off;
    logic          r;
    off = {1'b0, v} - {1'b0, w};
    r   = 1'b0;
    if (v >= w && off < (SN_W+1)'(WINDOW_DEPTH)) r = m[phys_fn(off[SW-1:0], b)];
    return r;
  endfunction

  state_t state;
  state_t ev_ret;
  state_t ra_ret;
  state_t w_ret;

  logic [WSIZE_W-1:0]      wsize;
  logic [LEN_W-1:0]        timeout;
  logic                    fpsw;

  logic [WINDOW_DEPTH-1:0] rmap;
  logic [SW-1:0]           base;
  logic [SN_W-1:0]         ws;
  logic [SN_W-1:0]         rs;
  logic [SN_W-1:0]         hi;
  logic [SN_W-1:0]         trig;
  logic                    running;
  logic [LEN_W-1:0]        tcount;
  logic                    started;

  logic                    held_v;
  logic [SN_W-1:0]         held_sn;
  logic [LEN_W-1:0]        held_size;
  logic [SN_W-1:0]         held_psn;

  chunk_t                  staging [MAX_CHUNKS];
  logic [CW-1:0]           stage_cnt;

  logic [SN_W-1:0]         cur_sn;
  logic [1:0]              cur_fi;
  logic [CW-1:0]           n_p;
  logic [CW-1:0]           j;
  logic [SW-1:0]           slot_r;
  logic [SN_W-1:0]         sh_a;
  logic [KW-1:0]           k;
  logic [KW-1:0]           kmax;
  logic [SN_W-1:0]         w_old;
  logic [SN_W-1:0]         sn_w;
  logic                    trig_en;

  logic [SW-1:0]           ra_pos;
  logic [SW-1:0]           ra_slot;
  logic [SN_W-1:0]         ra_psn;
  logic [1:0]              ra_fi;
  logic [CW-1:0]           ra_n;
  logic [CW-1:0]           ra_i;

  res_t                    ev;
  logic                    oq_rdy;

  logic                    c_we;
  logic [AW-1:0]           c_waddr;
  logic [AW-1:0]           c_raddr;
  chunk_t                  c_rdata;
  logic                    i_we;
  logic [1:0]              i_rfi;
  logic [CW-1:0]           i_rcnt;

  logic [SN_W:0]           effws;
  logic                    rx_sn;
  logic                    rx_rs;
  logic [SN_W:0]           sn_off;
  logic [SN_W:0]           sn_p1;
  logic [SN_W:0]           a_full;
  logic [SN_W:0]           a_lim;
  logic [SN_W:0]           w_off;
  logic [SN_W-1:0]         a_sel;
  act_t                    act;
  logic                    fmatch;
  logic [LEN_W:0]          total;

  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;

  always_comb begin
    if (started || wsize == '0) begin
      effws = (SN_W+1)'(1);
    end else if (KW'(wsize) > KW'(WINDOW_DEPTH) || 32'(wsize) > 32'(WINDOW_DEPTH)) begin
      effws = (SN_W+1)'(WINDOW_DEPTH);
    end else begin
      effws = (SN_W+1)'(wsize);
    end
  end

  assign rx_sn  = rx_fn(cur_sn, ws, base, rmap);
  assign rx_rs  = rx_fn(rs, ws, base, rmap);
  assign sn_off = {1'b0, cur_sn} - {1'b0, ws};
  assign sn_p1  = {1'b0, cur_sn} + 1'b1;
  assign a_full = sn_p1 - {1'b0, hi};
  assign a_lim  = sn_off;
  assign a_sel  = (a_full > a_lim) ? a_lim[SN_W-1:0] : a_full[SN_W-1:0];
  assign w_off  = {1'b0, sn_w} - {1'b0, ws};

  always_comb begin
    if (ra_n == CW'(1)) begin
      act = act_t'(ra_fi);
    end else if (ra_i == '0) begin
      act = ra_fi[1] ? ACT_LAST : ACT_WHOLE;
    end else if (ra_i == ra_n - 1'b1) begin
      act = ra_fi[0] ? ACT_FIRST : ACT_WHOLE;
    end else begin
      act = ACT_WHOLE;
    end
  end

  assign fmatch = held_v && (c_rdata.sdu_sn == held_sn) && (ra_psn == held_psn + 1'b1);
  assign total  = {1'b0, held_size} + {1'b0, c_rdata.len};

  assign c_we    = (state == S_P_COPY) && (j < n_p);
  assign c_waddr = AW'(slot_r) * AW'(MAX_CHUNKS) + AW'(j);
  assign c_raddr = AW'(ra_slot) * AW'(MAX_CHUNKS) + AW'(ra_i);
  assign i_we    = (state == S_P_COPY) && (j == '0);

  rlcr_store #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MAX_CHUNKS   (MAX_CHUNKS)
  ) u_store (
    .clk     (clk),
    .c_we    (c_we),
    .c_waddr (c_waddr),
    .c_wdata (staging[j[CIW-1:0]]),
    .c_raddr (c_raddr),
    .c_rdata (c_rdata),
    .i_we    (i_we),
    .i_waddr (slot_r),
    .i_wfi   (cur_fi),
    .i_wcnt  (n_p),
    .i_raddr (ra_slot),
    .i_rfi   (i_rfi),
    .i_rcnt  (i_rcnt)
  );

  rlcr_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (state == S_EMIT),
    .push_data (ev),
    .flush     (state == S_DONE),
    .rdy       (oq_rdy),
    .result    (result)
  );

  // staging buffer for the chunks of the open pdu
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item.valid && !item.func && stage_cnt < CW'(MAX_CHUNKS)) begin
      staging[stage_cnt[CIW-1:0]] <= '{sdu_sn: item.sdu_sn, len: item.chunk_len,
                                       sdu_len: item.sdu_len};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wsize     <= WSIZE_W'(16);
      timeout   <= LEN_W'(100);
      fpsw      <= 1'b0;
      rmap      <= '0;
      base      <= '0;
      ws        <= '0;
      rs        <= '0;
      hi        <= '0;
      trig      <= '0;
      running   <= 1'b0;
      tcount    <= '0;
      started   <= 1'b0;
      held_v    <= 1'b0;
      stage_cnt <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_WINDOW_SIZE:     wsize   <= cfg.data[WSIZE_W-1:0];
          CFG_REORDER_TIMEOUT: timeout <= cfg.data[LEN_W-1:0];
          CFG_FIRST_PDU_START: fpsw    <= cfg.data[0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (item.valid) begin
            if (item.func) begin
              if (!running) begin
                state <= S_DONE;
              end else if (tcount > LEN_W'(1)) begin
                tcount <= tcount - 1'b1;
                state  <= S_DONE;
              end else begin
                tcount  <= '0;
                running <= 1'b0;
                w_old   <= rs;
                trig_en <= 1'b1;
                w_ret   <= S_T_END;
                state   <= S_W_STEP;
              end
            end else begin
              if (stage_cnt < CW'(MAX_CHUNKS)) stage_cnt <= stage_cnt + 1'b1;
              if (item.chunk_last) begin
                n_p       <= (stage_cnt < CW'(MAX_CHUNKS)) ? stage_cnt + 1'b1 : stage_cnt;
                stage_cnt <= '0;
                cur_sn    <= item.pdu_sn;
                cur_fi    <= item.framing_info;
                state     <= S_P_CHECK;
              end else begin
                state <= S_DONE;
              end
            end
          end
        end

        S_P_CHECK: begin
          if (cur_sn == '1) begin
            ev     <= '{kind: EV_DISCARD, sn: cur_sn, len: '0};
            ev_ret <= S_DONE;
            state  <= S_EMIT;
          end else begin
            if (fpsw && !started) begin
              ws      <= cur_sn;
              rs      <= cur_sn;
              hi      <= cur_sn;
              trig    <= cur_sn;
              rmap    <= '0;
              started <= 1'b1;
            end
            state <= S_P_DISC;
          end
        end

        S_P_DISC: begin
          if (cur_sn < rs || (cur_sn < hi && rx_sn)) begin
            ev     <= '{kind: EV_DISCARD, sn: cur_sn, len: '0};
            ev_ret <= S_DONE;
            state  <= S_EMIT;
          end else if (cur_sn >= hi) begin
            hi <= sn_p1[SN_W-1:0];
            if ({1'b0, ws} + effws < sn_p1) begin
              sh_a  <= a_sel;
              k     <= '0;
              kmax  <= (a_sel >= SN_W'(WINDOW_DEPTH)) ? KW'(WINDOW_DEPTH) : a_sel[KW-1:0];
              state <= S_SH_LOOP;
            end else begin
              state <= S_P_STORE;
            end
          end else begin
            state <= S_P_STORE;
          end
        end

        S_SH_LOOP: begin
          if (k < kmax) begin
            ra_pos <= k[SW-1:0];
            k      <= k + 1'b1;
            ra_ret <= S_SH_LOOP;
            state  <= S_RA_START;
          end else begin
            ws <= ws + sh_a;
            if (sh_a < SN_W'(WINDOW_DEPTH)) base <= phys_fn(sh_a[SW-1:0], base);
            state <= S_SH_FIX;
          end
        end

        S_SH_FIX: begin
          if (rs < ws) rs <= ws;
          state <= S_P_STORE;
        end

        S_P_STORE: begin
          if (cur_sn < ws || sn_off >= (SN_W+1)'(WINDOW_DEPTH)) begin
            ev     <= '{kind: EV_DISCARD, sn: cur_sn, len: '0};
            ev_ret <= S_DONE;
            state  <= S_EMIT;
          end else begin
            slot_r <= phys_fn(sn_off[SW-1:0], base);
            j      <= '0;
            state  <= S_P_COPY;
          end
        end

        S_P_COPY: begin
          if (j < n_p) begin
            j <= j + 1'b1;
          end else begin
            rmap[slot_r] <= 1'b1;
            w_old        <= rs;
            trig_en      <= 1'b0;
            w_ret        <= S_P_TIMER;
            state        <= S_W_STEP;
          end
        end

        // advance the reordering point; skipping up to the trigger is one jump
        S_W_STEP: begin
          if (trig_en && rs < trig) begin
            rs <= trig;
            if (trig >= hi) state <= S_W_RA_INIT;
          end else if (rx_rs) begin
            rs <= rs + 1'b1;
            if ({1'b0, rs} + 1'b1 >= {1'b0, hi}) state <= S_W_RA_INIT;
          end else begin
            state <= S_W_RA_INIT;
          end
        end

        S_W_RA_INIT: begin
          sn_w  <= (w_old < ws) ? ws : w_old;
          state <= S_W_RA_LOOP;
        end

        S_W_RA_LOOP: begin
          if (sn_w < rs && w_off < (SN_W+1)'(WINDOW_DEPTH)) begin
            ra_pos <= w_off[SW-1:0];
            sn_w   <= sn_w + 1'b1;
            ra_ret <= S_W_RA_LOOP;
            state  <= S_RA_START;
          end else begin
            state <= w_ret;
          end
        end

        S_RA_START: begin
          ra_slot <= phys_fn(ra_pos, base);
          ra_psn  <= ws + SN_W'(ra_pos);
          state   <= S_RA_READ;
        end

        S_RA_READ: begin
          state <= rmap[ra_slot] ? S_RA_INFO : ra_ret;
        end

        S_RA_INFO: begin
          ra_fi <= i_rfi;
          ra_n  <= (i_rcnt > CW'(MAX_CHUNKS)) ? CW'(MAX_CHUNKS) : i_rcnt;
          ra_i  <= '0;
          state <= S_RA_CHK;
        end

        S_RA_CHK: begin
          if (ra_i < ra_n) begin
            state <= S_RA_ACT;
          end else begin
            rmap[ra_slot] <= 1'b0;
            state         <= ra_ret;
          end
        end

        S_RA_ACT: begin
          ra_i   <= ra_i + 1'b1;
          ev_ret <= S_RA_CHK;
          state  <= S_RA_CHK;
          case (act)
            ACT_WHOLE: begin
              state <= S_EMIT;
              if (c_rdata.len != c_rdata.sdu_len) begin
                ev <= '{kind: EV_LEN_ERR, sn: c_rdata.sdu_sn, len: '0};
              end else begin
                ev     <= '{kind: EV_DELIVER, sn: c_rdata.sdu_sn, len: c_rdata.sdu_len};
                held_v <= 1'b0;
              end
            end
            ACT_FIRST: begin
              held_v    <= 1'b1;
              held_sn   <= c_rdata.sdu_sn;
              held_size <= c_rdata.len;
              held_psn  <= ra_psn;
            end
            ACT_LAST: begin
              state <= S_EMIT;
              if (!fmatch || total < {1'b0, c_rdata.sdu_len}) begin
                held_v <= 1'b0;
                ev     <= '{kind: EV_FRAG_DROP, sn: c_rdata.sdu_sn, len: '0};
              end else if (total > {1'b0, c_rdata.sdu_len}) begin
                ev <= '{kind: EV_LEN_ERR, sn: c_rdata.sdu_sn, len: '0};
              end else begin
                held_v <= 1'b0;
                ev     <= '{kind: EV_DELIVER, sn: c_rdata.sdu_sn, len: c_rdata.sdu_len};
              end
            end
            ACT_MID: begin
              if (!fmatch) begin
                held_v <= 1'b0;
                ev     <= '{kind: EV_FRAG_DROP, sn: c_rdata.sdu_sn, len: '0};
                state  <= S_EMIT;
              end else begin
                held_size <= total[LEN_W] ? '1 : total[LEN_W-1:0];
                held_psn  <= ra_psn;
              end
            end
            default: ;
          endcase
        end

        S_P_TIMER: begin
          if (!(running && !(trig <= rs || trig < ws || trig > hi)) && hi > rs) begin
            running <= 1'b1;
            tcount  <= (timeout == '0) ? LEN_W'(1) : timeout;
            trig    <= hi;
          end else if (running && (trig <= rs || trig < ws || trig > hi)) begin
            running <= 1'b0;
          end
          state <= S_DONE;
        end

        S_T_END: begin
          if (hi > rs) begin
            trig    <= hi;
            running <= 1'b1;
            tcount  <= (timeout == '0) ? LEN_W'(1) : timeout;
          end
          state <= S_DONE;
        end

        S_EMIT: begin
          if (oq_rdy) state <= ev_ret;
        end

        S_DONE: begin
          if (oq_rdy) state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* tb/sv/rlcr_checker.sv */
`timescale 1ns / 1ps
module rlcr_checker import rlcr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  rlcr_item_if      item,
  rlcr_result_if    result,
  rlcr_cfg_if       cfg,
  output int        fail_count,
  output int        exp_count,
  output int        events_seen
);

  typedef longint unsigned u64_t;

  typedef struct {
    ev_t              kind;
    logic [SN_W-1:0]  sn;
    logic [LEN_W-1:0] len;
    logic             last;
  } sdu_event_t;

  localparam int   DEPTH   = RLCR_WINDOW_DEPTH;
  localparam int   NCHUNK  = RLCR_MAX_CHUNKS;
  localparam u64_t SN_MASK = 64'hFFFF_FFFF;
  localparam u64_t LEN_MAX = 64'hFFFF;

  sdu_event_t pending_events[$];
  int         step_events;

  u64_t   win_size_reg, timeout_reg;
  bit     first_pdu_reg;
  bit     rx_map[DEPTH];
  chunk_t chunk_mem[DEPTH*NCHUNK];
  act_t   slot_fi[DEPTH];
  int     slot_cnt[DEPTH];
  chunk_t staged[NCHUNK];
  int     staged_n;
  u64_t   win_start, reorder_sn, top_sn, trigger_sn;
  bit     timer_on;
  u64_t   timer_left;
  bit     held_valid;
  u64_t   held_sdu_sn, held_size, held_pdu_sn;
  bit     mc_started;

  initial begin
    fail_count  = 0;
    exp_count   = 0;
    events_seen = 0;
  end

  function automatic void reset_state();
    win_size_reg  = 16;
    timeout_reg   = 100;
    first_pdu_reg = 0;
    foreach (rx_map[i]) rx_map[i] = 0;
    staged_n   = 0;
    win_start  = 0;
    reorder_sn = 0;
    top_sn     = 0;
    trigger_sn = 0;
    timer_on   = 0;
    timer_left = 0;
    held_valid = 0;
    held_sdu_sn = 0;
    held_size  = 0;
    held_pdu_sn = 0;
    mc_started = 0;
  endfunction

  function automatic void emit_event(ev_t k, u64_t sn, u64_t len);
    sdu_event_t e;
    if (step_events >= MAX_RESULTS) return;
    e.kind = k;
    e.sn   = sn[SN_W-1:0];
    e.len  = len[LEN_W-1:0];
    e.last = 0;
    pending_events.push_back(e);
    step_events++;
  endfunction

  function automatic u64_t window_span();
    if (mc_started) return 1;
    if (win_size_reg < 1) return 1;
    if (win_size_reg > DEPTH) return DEPTH;
    return win_size_reg;
  endfunction

  function automatic bit slot_received(u64_t sn);
    if (sn < win_start) return 0;
    if (sn - win_start >= DEPTH) return 0;
    return rx_map[sn - win_start];
  endfunction

  function automatic void clear_held();
    held_valid  = 0;
    held_sdu_sn = 0;
    held_size   = 0;
    held_pdu_sn = 0;
  endfunction

  function automatic void hold_first(chunk_t c, u64_t psn);
    held_valid  = 1;
    held_sdu_sn = c.sdu_sn;
    held_size   = c.len;
    held_pdu_sn = psn;
  endfunction

  function automatic void take_whole(chunk_t c);
    if (c.len != c.sdu_len) begin
      emit_event(EV_LEN_ERR, c.sdu_sn, 0);
      return;
    end
    emit_event(EV_DELIVER, c.sdu_sn, c.sdu_len);
    clear_held();
  endfunction

  function automatic bit frag_matches(chunk_t c, u64_t psn);
    return held_valid && (u64_t'(c.sdu_sn) == held_sdu_sn) &&
           (psn == ((held_pdu_sn + 1) & SN_MASK));
  endfunction

  function automatic void take_last(chunk_t c, u64_t psn);
    u64_t total;
    if (!frag_matches(c, psn)) begin
      clear_held();
      emit_event(EV_FRAG_DROP, c.sdu_sn, 0);
      return;
    end
    total = held_size + c.len;
    if (total < c.sdu_len) begin
      clear_held();
      emit_event(EV_FRAG_DROP, c.sdu_sn, 0);
      return;
    end
    if (total > c.sdu_len) begin
      emit_event(EV_LEN_ERR, c.sdu_sn, 0);
      return;
    end
    emit_event(EV_DELIVER, c.sdu_sn, c.sdu_len);
    clear_held();
  endfunction

  function automatic void take_mid(chunk_t c, u64_t psn);
    if (!frag_matches(c, psn)) begin
      clear_held();
      emit_event(EV_FRAG_DROP, c.sdu_sn, 0);
      return;
    end
    held_size += c.len;
    if (held_size > LEN_MAX) held_size = LEN_MAX;
    held_pdu_sn = psn;
  endfunction

  function automatic void reassemble_slot(u64_t pos);
    u64_t   psn;
    act_t   fi;
    int     n;
    chunk_t c;
    if (pos >= DEPTH || !rx_map[pos]) return;
    psn = (win_start + pos) & SN_MASK;
    fi  = slot_fi[pos];
    n   = slot_cnt[pos];
    for (int i = 0; i < n; i++) begin
      c = chunk_mem[pos*NCHUNK + i];
      if (n == 1) begin
        case (fi)
          ACT_WHOLE: take_whole(c);
          ACT_FIRST: hold_first(c, psn);
          ACT_LAST:  take_last(c, psn);
          default:   take_mid(c, psn);
        endcase
      end else if (i == 0) begin
        if (fi[1]) take_last(c, psn);
        else take_whole(c);
      end else if (i == n - 1) begin
        if (fi[0]) hold_first(c, psn);
        else take_whole(c);
      end else begin
        take_whole(c);
      end
    end
    rx_map[pos] = 0;
  endfunction

  function automatic void slide_window(u64_t a);
    u64_t s;
    if (a == 0) return;
    for (int d = 0; d < DEPTH; d++) begin
      s = d + a;
      if (a < DEPTH && s < DEPTH) begin
        rx_map[d]   = rx_map[s];
        slot_fi[d]  = slot_fi[s];
        slot_cnt[d] = slot_cnt[s];
        for (int k = 0; k < NCHUNK; k++) chunk_mem[d*NCHUNK + k] = chunk_mem[s*NCHUNK + k];
      end else begin
        rx_map[d] = 0;
      end
    end
    win_start += a;
  endfunction

  function automatic void reorder_walk(bit use_trigger);
    u64_t old, sn;
    old = reorder_sn;
    while (slot_received(reorder_sn) || (use_trigger && reorder_sn < trigger_sn)) begin
      reorder_sn++;
      if (reorder_sn >= top_sn) break;
    end
    sn = (old < win_start) ? win_start : old;
    for (; sn < reorder_sn && sn - win_start < DEPTH; sn++) reassemble_slot(sn - win_start);
  endfunction

  function automatic void timer_arm();
    timer_on   = 1;
    timer_left = timeout_reg ? timeout_reg : 1;
  endfunction

  function automatic void close_pdu(u64_t sn, logic [1:0] fi);
    u64_t ws, old, a, lim, idx;
    sn &= SN_MASK;
    if (sn == SN_MASK) begin
      emit_event(EV_DISCARD, sn, 0);
      return;
    end
    if (first_pdu_reg && !mc_started) begin
      win_start  = sn;
      reorder_sn = sn;
      top_sn     = sn;
      trigger_sn = sn;
      foreach (rx_map[i]) rx_map[i] = 0;
      mc_started = 1;
    end
    ws = window_span();
    if (sn < reorder_sn || (sn < top_sn && slot_received(sn))) begin
      emit_event(EV_DISCARD, sn, 0);
      return;
    end
    if (sn >= top_sn) begin
      old    = top_sn;
      top_sn = sn + 1;
      if (win_start + ws < top_sn) begin
        a   = top_sn - old;
        lim = sn - win_start;
        if (a > lim) a = lim;
        for (u64_t k = 0; k < a && k < DEPTH; k++) reassemble_slot(k);
        slide_window(a);
        if (reorder_sn < win_start) reorder_sn = win_start;
      end
    end
    idx = sn - win_start;
    if (idx >= DEPTH) begin
      emit_event(EV_DISCARD, sn, 0);
      return;
    end
    slot_fi[idx]  = act_t'(fi);
    slot_cnt[idx] = staged_n;
    for (int k = 0; k < staged_n; k++) chunk_mem[idx*NCHUNK + k] = staged[k];
    rx_map[idx] = 1;
    reorder_walk(0);
    if (timer_on && (trigger_sn <= reorder_sn || trigger_sn < win_start || trigger_sn > top_sn))
      timer_on = 0;
    if (!timer_on && top_sn > reorder_sn) begin
      timer_arm();
      trigger_sn = top_sn;
    end
  endfunction

  function automatic void timer_tick();
    if (!timer_on) return;
    if (timer_left > 1) begin
      timer_left--;
      return;
    end
    timer_left = 0;
    timer_on   = 0;
    reorder_walk(1);
    if (top_sn > reorder_sn) begin
      trigger_sn = top_sn;
      timer_arm();
    end
  endfunction

  function automatic void predict_beat();
    step_events = 0;
    if (item.func) begin
      timer_tick();
    end else begin
      if (staged_n < NCHUNK) begin
        staged[staged_n].sdu_sn  = item.sdu_sn;
        staged[staged_n].len     = item.chunk_len;
        staged[staged_n].sdu_len = item.sdu_len;
        staged_n++;
      end
      if (item.chunk_last) begin
        close_pdu(item.pdu_sn, item.framing_info);
        staged_n = 0;
      end
    end
    if (step_events > 0) pending_events[pending_events.size()-1].last = 1;
  endfunction

  always @(posedge clk) begin
    sdu_event_t e;
    if (rst) begin
      reset_state();
      pending_events.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_idx_t'(cfg.index))
          CFG_WINDOW_SIZE:     win_size_reg  = cfg.data & 16'h1F;
          CFG_REORDER_TIMEOUT: timeout_reg   = cfg.data;
          CFG_FIRST_PDU_START: first_pdu_reg = cfg.data[0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        events_seen++;
        if (pending_events.size() == 0) begin
          $error("unexpected result beat: event_kind %0d out_sdu_sn %0h",
                 result.event_kind, result.out_sdu_sn);
          fail_count++;
        end else begin
          e = pending_events.pop_front();
          if (result.event_kind !== e.kind) begin
            $error("event_kind: expected %0d, got %0d", e.kind, result.event_kind);
            fail_count++;
          end
          if (result.out_sdu_sn !== e.sn) begin
            $error("out_sdu_sn: expected %0h, got %0h", e.sn, result.out_sdu_sn);
            fail_count++;
          end
          if (result.out_sdu_len !== e.len) begin
            $error("out_sdu_len: expected %0d, got %0d", e.len, result.out_sdu_len);
            fail_count++;
          end
          if (result.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, result.last);
            fail_count++;
          end
        end
      end
      if (item.valid && item.ready) predict_beat();
    end
    exp_count = pending_events.size();
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import rlcr_pkg::*;

  typedef struct {
    logic             func;
    logic [SN_W-1:0]  psn;
    logic [1:0]       fi;
    logic             lst;
    logic [LEN_W-1:0] clen;
    logic [SN_W-1:0]  ssn;
    logic [LEN_W-1:0] slen;
  } chunk_beat_t;
  typedef chunk_beat_t beat_q_t[$];

  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 600;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst;
  int   fail_count, exp_count, events_seen;
  int   send_idle, recv_stall;
  int   hold_req, hold_seen;
  int   beats_sent, quiet;
  longint unsigned next_psn;
  logic [SN_W-1:0] next_sdu;
  bit   open_valid;
  logic [SN_W-1:0] open_sn;
  int   open_len, open_sent;

  rlcr_item_if   item ();
  rlcr_result_if result ();
  rlcr_cfg_if    cfg ();

  rlc_um_reorder_reassemble u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg)
  );

  rlcr_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .result      (result),
    .cfg         (cfg),
    .fail_count  (fail_count),
    .exp_count   (exp_count),
    .events_seen (events_seen)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    result.ready = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        result.ready = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      result.ready = ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet = 0;
    end else begin
      if ((item.valid && item.ready) || (result.valid && result.ready) ||
          (cfg.valid && cfg.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("rlc_um_reorder_reassemble verification failed");
        $finish;
      end
    end
  end

  task automatic send_beat(chunk_beat_t b);
    while ($urandom_range(99) < send_idle) begin
      item.valid = 0;
      @(negedge clk);
    end
    item.func         = b.func;
    item.pdu_sn       = b.psn;
    item.framing_info = b.fi;
    item.chunk_last   = b.lst;
    item.chunk_len    = b.clen;
    item.sdu_sn       = b.ssn;
    item.sdu_len      = b.slen;
    item.valid        = 1;
    do @(posedge clk); while (!item.ready);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_pdu(beat_q_t q);
    foreach (q[i]) send_beat(q[i]);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg.index = idx;
    cfg.data  = value;
    cfg.valid = 1;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 0;
  endtask

  task automatic drain();
    item.valid = 0;
    while (exp_count != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  function automatic chunk_beat_t rand_beat();
    chunk_beat_t b;
    b.func = 1'($urandom_range(1));
    b.psn  = $urandom;
    b.fi   = 2'($urandom_range(3));
    b.lst  = 0;
    b.clen = LEN_W'($urandom);
    b.ssn  = $urandom;
    b.slen = LEN_W'($urandom);
    return b;
  endfunction

  function automatic chunk_beat_t mk(longint unsigned psn, logic [1:0] fi, logic lst,
                                     int clen, logic [SN_W-1:0] ssn, int slen);
    chunk_beat_t b;
    b.func = 0;
    b.psn  = psn[SN_W-1:0];
    b.fi   = fi;
    b.lst  = lst;
    b.clen = LEN_W'(clen);
    b.ssn  = ssn;
    b.slen = LEN_W'(slen);
    return b;
  endfunction

  function automatic chunk_beat_t mk_tick();
    chunk_beat_t b;
    b = rand_beat();
    b.func = 1;
    return b;
  endfunction

  function automatic beat_q_t build_pdu(longint unsigned psn);
    beat_q_t     q;
    chunk_beat_t b;
    logic [1:0]  fi;
    int          n, rem, part;
    fi = 0;
    n  = ($urandom_range(99) < 5) ? $urandom_range(5, 6) : $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      b = rand_beat();
      b.func = 0;
      if (i == 0 && open_valid && $urandom_range(99) < 85) begin
        rem = open_len - open_sent;
        if (n == 1 && rem > 1 && $urandom_range(1)) begin
          part = $urandom_range(1, rem - 1);
          fi = ACT_MID;
          open_sent += part;
        end else begin
          part = rem;
          fi[1] = 1;
          open_valid = 0;
        end
        b.ssn  = open_sn ^ SN_W'(($urandom_range(99) < 8) ? 1 : 0);
        b.slen = LEN_W'(open_len);
        b.clen = LEN_W'(part);
      end else if (i == n - 1 && $urandom_range(99) < 40) begin
        open_sn   = next_sdu++;
        open_len  = $urandom_range(2, 3000);
        part      = $urandom_range(1, open_len - 1);
        open_sent = part;
        open_valid = 1;
        fi[0] = 1;
        b.ssn  = open_sn;
        b.slen = LEN_W'(open_len);
        b.clen = LEN_W'(part);
      end else begin
        if (i == 0) open_valid = 0;
        b.ssn  = next_sdu++;
        b.slen = ($urandom_range(99) < 5) ? 16'hFFFF : LEN_W'($urandom_range(0, 2000));
        b.clen = ($urandom_range(99) < 8) ? b.slen + 16'd1 : b.slen;
      end
      q.push_back(b);
    end
    q[n-1].lst = 1;
    q[n-1].psn = psn[SN_W-1:0];
    q[n-1].fi  = fi;
    return q;
  endfunction

  task automatic run_phase(int count);
    beat_q_t cur, held, prev;
    bit      have_held;
    int      sent, r, k;
    chunk_beat_t b;
    sent = 0;
    have_held = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      if (r < 12) begin
        k = $urandom_range(1, 6);
        repeat (k) send_beat(mk_tick());
        sent += k;
      end else if (r < 16) begin
        b = rand_beat();
        send_beat(b);
        sent++;
      end else begin
        cur = build_pdu(next_psn);
        next_psn++;
        r = $urandom_range(99);
        if (r < 6) continue;
        if (r < 18 && !have_held) begin
          held = cur;
          have_held = 1;
          continue;
        end
        send_pdu(cur);
        sent += cur.size();
        if (have_held) begin
          send_pdu(held);
          sent += held.size();
          have_held = 0;
        end
        if (r >= 94 && prev.size() != 0) send_pdu(prev);
        prev = cur;
      end
    end
    if (have_held) send_pdu(held);
  endtask

  task automatic directed();
    beat_q_t q;
    send_beat(mk(0, ACT_WHOLE, 1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
    send_beat(mk(0, ACT_WHOLE, 1, 4, 1, 4));
    send_beat(mk(32'hFFFF_FFFF, ACT_WHOLE, 1, 4, 2, 4));
    send_beat(mk(1, ACT_WHOLE, 1, 5, 3, 6));
    for (int i = 0; i < 6; i++) q.push_back(mk(2, ACT_WHOLE, i == 5, 10 + i, 10 + i, 10 + i));
    send_pdu(q);
    send_beat(mk(3, ACT_FIRST, 1, 65000, 77, 16'hFFFF));
    send_beat(mk(4, ACT_MID, 1, 2000, 77, 16'hFFFF));
    send_beat(mk(5, ACT_LAST, 1, 0, 77, 16'hFFFF));
    send_beat(mk(6, ACT_FIRST, 1, 10, 80, 30));
    send_beat(mk(7, ACT_FIRST, 1, 5, 81, 9));
    send_beat(mk(8, ACT_LAST, 1, 4, 81, 9));
    send_beat(mk(9, ACT_LAST, 1, 4, 99, 9));
    send_beat(mk(10, ACT_FIRST, 1, 3, 100, 10));
    send_beat(mk(11, ACT_LAST, 1, 3, 100, 10));
    send_beat(mk(12, ACT_FIRST, 1, 8, 101, 10));
    send_beat(mk(13, ACT_LAST, 1, 8, 101, 10));
    send_beat(mk(15, ACT_WHOLE, 1, 7, 103, 7));
    send_beat(mk(14, ACT_WHOLE, 1, 7, 102, 7));
    send_beat(mk(17, ACT_WHOLE, 1, 7, 104, 7));
    repeat (3) send_beat(mk_tick());
    send_beat(mk(30, ACT_WHOLE, 1, 7, 105, 7));
    next_psn = 31;
    next_sdu = 200;
  endtask

  initial begin
    rst = 1;
    item.valid = 0;
    item.func = 0;
    item.pdu_sn = 0;
    item.framing_info = 0;
    item.chunk_last = 0;
    item.chunk_len = 0;
    item.sdu_sn = 0;
    item.sdu_len = 0;
    cfg.valid = 0;
    cfg.index = CFG_WINDOW_SIZE;
    cfg.data = 0;
    send_idle = 0;
    recv_stall = 0;
    hold_req = 0;
    beats_sent = 0;
    open_valid = 0;
    open_sn = 0;
    open_len = 0;
    open_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    directed();
    drain();

    write_reg(CFG_WINDOW_SIZE, 16);
    write_reg(CFG_REORDER_TIMEOUT, 1);
    write_reg(CFG_FIRST_PDU_START, 0);
    run_phase(20);
    drain();

    write_reg(CFG_WINDOW_SIZE, 1);
    write_reg(CFG_REORDER_TIMEOUT, 16'hFFFF);
    send_idle = 70;
    run_phase(20);
    drain();

    write_reg(CFG_WINDOW_SIZE, 5);
    write_reg(CFG_REORDER_TIMEOUT, 4);
    send_idle = 0;
    recv_stall = 70;
    hold_req++;
    run_phase(20);
    drain();

    write_reg(CFG_WINDOW_SIZE, 31);
    write_reg(CFG_REORDER_TIMEOUT, 2);
    send_idle = 22;
    recv_stall = 22;
    hold_req++;
    run_phase(20);
    drain();

    write_reg(CFG_WINDOW_SIZE, 0);
    write_reg(CFG_REORDER_TIMEOUT, 3);
    write_reg(CFG_FIRST_PDU_START, 1);
    next_psn = 64'hFFFF_FFE8;
    run_phase(20);
    send_beat(mk(32'hFFFF_FFFF, ACT_WHOLE, 1, 1, 500, 1));
    drain();

    $display("sent %0d item beats and checked %0d result beats across six register settings",
             beats_sent, events_seen);
    $display("covered reordering, timer expiry, fragment reassembly and multicast window start");
    if (fail_count == 0) begin
      $display("rlc_um_reorder_reassemble verification clean");
    end else begin
      $display("rlc_um_reorder_reassemble verification failed");
    end
    $finish;
  end

endmodule
